// ===== rtl/ssm_pkg.sv =====
package ssm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_A = 2'd0,
    CMD_PUSH_B = 2'd1,
    CMD_END_A  = 2'd2,
    CMD_END_B  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic              is_push;
    logic              sel_b;
    logic [DATA_W-1:0] value;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_DECIDE
  } back_state_e;

endpackage

// ===== rtl/ssm_ram.sv =====
module ssm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ssm_front.sv =====
module ssm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [ssm_pkg::CMD_W-1:0]  s_cmd_i,
  input  logic [ssm_pkg::DATA_W-1:0] s_value_i,
  output ssm_pkg::queue_head_t       head_o,
  input  logic                       pop_i
);
  import ssm_pkg::*;

  // two-entry item queue toward the execute side
  queue_item_t slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  queue_item_t item_in;
  logic        push, pop;

  always_comb begin
    item_in.value = s_value_i;
    unique case (cmd_e'(s_cmd_i))
      CMD_PUSH_A: begin
        item_in.is_push = 1'b1;
        item_in.sel_b   = 1'b0;
      end
      CMD_PUSH_B: begin
        item_in.is_push = 1'b1;
        item_in.sel_b   = 1'b1;
      end
      CMD_END_A: begin
        item_in.is_push = 1'b0;
        item_in.sel_b   = 1'b0;
      end
      CMD_END_B: begin
        item_in.is_push = 1'b0;
        item_in.sel_b   = 1'b1;
      end
      default: begin
        item_in.is_push = 1'b0;
        item_in.sel_b   = 1'b0;
      end
    endcase
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign pop       = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

  a_ptr_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop_i) |=> (cnt_q == 2'd2))
    else $error("full queue lost an entry");

endmodule

// ===== rtl/ssm_back.sv =====
module ssm_back #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssm_pkg::queue_head_t       head_i,
  output logic                       pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [ssm_pkg::DATA_W-1:0] m_value_o,
  output logic                       m_last_o,
  output logic                       m_empty_o,
  output logic                       m_ovf_o
);
  import ssm_pkg::*;

  localparam int unsigned PTR_W = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  back_state_e state_q, state_d;

  logic [PTR_W-1:0] a_rp_q, a_rp_d, b_rp_q, b_rp_d;
  logic [CNT_W-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic             a_end_q, a_end_d, b_end_q, b_end_d;
  logic             ovf_q, ovf_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  logic              out_empty_q, out_empty_d;
  logic              out_ovf_q, out_ovf_d;

  logic [DATA_W-1:0] a_head, b_head;
  logic [PTR_W-1:0]  a_waddr, b_waddr;
  logic [SUM_W-1:0]  a_sum, b_sum;
  logic              a_we, b_we;
  logic              a_full, b_full;
  logic              take_a, take_b, emit, marker, last, out_free, out_load;
  logic [CNT_W-1:0]  a_cnt_after, b_cnt_after;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // write slot is rp + count, wrapped once
  always_comb begin
    a_sum   = SUM_W'(a_rp_q) + SUM_W'(a_cnt_q);
    b_sum   = SUM_W'(b_rp_q) + SUM_W'(b_cnt_q);
    a_waddr = (a_sum >= SUM_W'(LIST_DEPTH)) ? PTR_W'(a_sum - SUM_W'(LIST_DEPTH))
                                            : PTR_W'(a_sum);
    b_waddr = (b_sum >= SUM_W'(LIST_DEPTH)) ? PTR_W'(b_sum - SUM_W'(LIST_DEPTH))
                                            : PTR_W'(b_sum);
  end

  assign a_full = (a_cnt_q == CNT_W'(LIST_DEPTH));
  assign b_full = (b_cnt_q == CNT_W'(LIST_DEPTH));
  assign pop_o  = (state_q == BK_IDLE) && head_i.valid;
  assign a_we   = pop_o && head_i.item.is_push && !head_i.item.sel_b && !a_end_q && !a_full;
  assign b_we   = pop_o && head_i.item.is_push && head_i.item.sel_b && !b_end_q && !b_full;

  ssm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (head_i.item.value),
    .raddr_i (a_rp_q),
    .rdata_o (a_head)
  );

  ssm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (head_i.item.value),
    .raddr_i (b_rp_q),
    .rdata_o (b_head)
  );

  // merge decision; tie goes to A
  always_comb begin
    if (a_cnt_q != '0 && b_cnt_q != '0) begin
      take_a = ($signed(a_head) <= $signed(b_head));
      take_b = !take_a;
    end else begin
      take_a = (a_cnt_q != '0) && b_end_q && (a_cnt_q >= CNT_W'(2) || a_end_q);
      take_b = (b_cnt_q != '0) && a_end_q && (b_cnt_q >= CNT_W'(2) || b_end_q);
    end
    emit        = take_a || take_b;
    a_cnt_after = take_a ? a_cnt_q - 1'b1 : a_cnt_q;
    b_cnt_after = take_b ? b_cnt_q - 1'b1 : b_cnt_q;
    last        = a_end_q && b_end_q && a_cnt_after == '0 && b_cnt_after == '0;
    marker      = !emit && a_end_q && b_end_q && a_cnt_q == '0 && b_cnt_q == '0;
  end

  assign out_free = !out_valid_q || m_ready_i;
  assign out_load = (state_q == BK_DECIDE) && (emit || marker) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (head_i.valid) begin
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: state_d = BK_DECIDE;
      BK_DECIDE: begin
        if (!emit && !marker) begin
          state_d = BK_IDLE;
        end else if (out_free) begin
          state_d = (marker || last) ? BK_IDLE : BK_FETCH;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    a_rp_d      = a_rp_q;
    b_rp_d      = b_rp_q;
    a_cnt_d     = a_cnt_q;
    b_cnt_d     = b_cnt_q;
    a_end_d     = a_end_q;
    b_end_d     = b_end_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_ovf_d   = out_ovf_q;

    if (pop_o) begin
      if (head_i.item.is_push) begin
        if (a_we) begin
          a_cnt_d = a_cnt_q + 1'b1;
        end
        if (b_we) begin
          b_cnt_d = b_cnt_q + 1'b1;
        end
        if ((!head_i.item.sel_b && !a_end_q && a_full) ||
            (head_i.item.sel_b && !b_end_q && b_full)) begin
          ovf_d = 1'b1;
        end
      end else if (head_i.item.sel_b) begin
        b_end_d = 1'b1;
      end else begin
        a_end_d = 1'b1;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      out_ovf_d   = ovf_q;
      out_last_d  = marker || last;
      out_empty_d = marker;
      out_value_d = marker ? '0 : (take_a ? a_head : b_head);
      if (take_a) begin
        a_rp_d = ptr_inc(a_rp_q);
      end
      if (take_b) begin
        b_rp_d = ptr_inc(b_rp_q);
      end
      a_cnt_d = a_cnt_after;
      b_cnt_d = b_cnt_after;
      if (marker || last) begin
        a_end_d = 1'b0;
        b_end_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      a_rp_q      <= '0;
      b_rp_q      <= '0;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      a_end_q     <= 1'b0;
      b_end_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_rp_q      <= a_rp_d;
      b_rp_q      <= b_rp_d;
      a_cnt_q     <= a_cnt_d;
      b_cnt_q     <= b_cnt_d;
      a_end_q     <= a_end_d;
      b_end_q     <= b_end_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_value_o = out_value_q;
  assign m_last_o  = out_last_q;
  assign m_empty_o = out_empty_q;
  assign m_ovf_o   = out_ovf_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_cnt_q <= CNT_W'(LIST_DEPTH)) && (b_cnt_q <= CNT_W'(LIST_DEPTH)))
    else $error("list count out of range");

  a_fetch_then_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FETCH) |=> (state_q == BK_DECIDE))
    else $error("head fetch not followed by decision");

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> (out_last_q && out_value_q == '0))
    else $error("empty marker malformed");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (marker || last)) |=>
      (!a_end_q && !b_end_q && !ovf_q && a_cnt_q == '0 && b_cnt_q == '0))
    else $error("merge state not cleared after final item");

endmodule

// ===== rtl/sorted_stream_merge.sv =====
// Merges two ascending lists of signed 32-bit values into one ascending stream.
// Each input item pushes a value onto list A or B (tuser 0/1) or ends A or B
// (tuser 2/3). Ties go to A; the final result of a merge carries tlast, and two
// empty lists give one result with tuser[0] set and zero data. A push onto a
// full list (LIST_DEPTH entries) is dropped and raises the sticky overflow flag
// (tuser[1]) until the merge completes; a push onto an ended list is dropped.
// A two-entry queue decouples input from execution. The execute stage takes an
// item only when idle, then passes through a fetch state for the registered read
// of the list RAM and a decide state; each result it emits ahead of the final
// result of a merge sends it back to fetch, since a head must be refetched.
module sorted_stream_merge #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ssm_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] value
  input  logic [ssm_pkg::CMD_W-1:0]  s_axis_tuser,  // [1:0] command
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [ssm_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] merged_value
  output logic                       m_axis_tlast,
  output logic [1:0]                 m_axis_tuser   // [0] empty_merge, [1] overflow
);
  import ssm_pkg::*;

  queue_head_t head;
  logic        pop;

  ssm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_cmd_i   (s_axis_tuser),
    .s_value_i (s_axis_tdata),
    .head_o    (head),
    .pop_i     (pop)
  );

  ssm_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_value_o (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_empty_o (m_axis_tuser[0]),
    .m_ovf_o   (m_axis_tuser[1])
  );

endmodule
